### rtl/ile_pkg.sv
// ---------------------------------------------------------------------------
// ile_pkg: shared types and codes for the indexed list engine
// Operation and status codes, the per-cell command struct and the field
// widths of both channels.
// ---------------------------------------------------------------------------
package ile_pkg;

  localparam int MODE_W   = 2;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  // Operation codes on the input channel
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Capacity limit after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // Action broadcast to the cell row
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INS,
    ACT_APP,
    ACT_DEL
  } act_t;

  typedef struct packed {
    act_t             act;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

### rtl/ile_in_if.sv
// ---------------------------------------------------------------------------
// ile_in_if: request channel of the indexed list engine
// Valid/ready handshake carrying one operation beat.
// ---------------------------------------------------------------------------
interface ile_in_if
  import ile_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] entry_data;

  modport source (output valid, output mode, output position, output entry_data,
                  input ready);
  modport sink   (input valid, input mode, input position, input entry_data,
                  output ready);
endinterface

### rtl/ile_out_if.sv
// ---------------------------------------------------------------------------
// ile_out_if: result channel of the indexed list engine
// Valid/ready handshake carrying one result beat.
// ---------------------------------------------------------------------------
interface ile_out_if
  import ile_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_data;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output read_data, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_data, input entry_count,
                  output ready);
endinterface

### rtl/ile_cell.sv
// ---------------------------------------------------------------------------
// ile_cell: one slot of the list
// Holds one entry and, on each broadcast command, keeps it, loads new data,
// or takes the value of its left or right neighbor.
// ---------------------------------------------------------------------------
module ile_cell
  import ile_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_cmd_t              cmd,
  input  logic [ENTRY_WIDTH-1:0] wr_data,
  input  logic [ENTRY_WIDTH-1:0] left,
  input  logic [ENTRY_WIDTH-1:0] right,
  output logic [ENTRY_WIDTH-1:0] entry
);

  int pos_i;
  int cnt_i;
  logic [ENTRY_WIDTH-1:0] entry_next;

  // Decide this slot's move from the broadcast command
  always_comb begin
    pos_i      = int'(cmd.pos);
    cnt_i      = int'(cmd.count);
    entry_next = entry;
    case (cmd.act)
      ACT_INS: begin
        if (IDX == pos_i) begin
          entry_next = wr_data;
        end else if (IDX > pos_i && IDX <= cnt_i) begin
          entry_next = left;
        end
      end
      ACT_APP: begin
        if (IDX == cnt_i) begin
          entry_next = wr_data;
        end
      end
      ACT_DEL: begin
        if (IDX >= pos_i && IDX + 1 < cnt_i) begin
          entry_next = right;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // Hold the entry; payload needs no reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### rtl/indexed_list_engine_unit.sv
// ---------------------------------------------------------------------------
// indexed_list_engine_unit: bounded ordered list with insert/append/delete/get
// A row of DEPTH cells holds the list and shifts every entry at once.
// ---------------------------------------------------------------------------
// The row of cells moves all entries at the same clock edge that takes a
// request, and the result lands in an output register, so a new request
// beat is taken every cycle while the result side keeps up
// (ready drops only while a result waits unclaimed). Each request yields one
// result beat with status (done, full, index out of range), the entry read
// by a get (zero otherwise) and the entry count after the operation. The
// capacity limit register may be written only while no request is in flight;
// limits above DEPTH act as DEPTH, and zero refuses every insert and append.
module indexed_list_engine_unit
  import ile_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  ile_in_if.sink           in_ch,
  ile_out_if.source        out_ch
);

  localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] capacity_limit;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_read_data;
  logic [CNT_W-1:0]    out_count;

  logic                   take;
  logic                   full;
  int                     eff_limit;
  cell_cmd_t              cmd;
  logic [STATUS_W-1:0]    status_next;
  logic [DATA_W-1:0]      rd_next;
  logic [IW-1:0]          rd_idx;
  logic [ENTRY_WIDTH-1:0] wr_data;
  logic [ENTRY_WIDTH-1:0] cell_q [DEPTH];

  // Accept a beat whenever the output register is free or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  assign wr_data = ENTRY_WIDTH'(in_ch.entry_data);
  assign rd_idx  = IW'(in_ch.position);

  // Decode the operation and check it against count and limit
  always_comb begin
    eff_limit   = (int'(capacity_limit) > DEPTH) ? DEPTH : int'(capacity_limit);
    full        = int'(count) >= eff_limit;
    cmd.act     = ACT_NONE;
    cmd.pos     = in_ch.position;
    cmd.count   = count;
    status_next = ST_DONE;
    rd_next     = '0;
    count_next  = count;
    case (in_ch.mode)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (in_ch.position > count) begin
          status_next = ST_RANGE;
        end else begin
          cmd.act    = ACT_INS;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.act    = ACT_APP;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (in_ch.position >= count) begin
          status_next = ST_RANGE;
        end else begin
          cmd.act    = ACT_DEL;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        if (in_ch.position >= count) begin
          status_next = ST_RANGE;
        end else begin
          rd_next = DATA_W'(cell_q[rd_idx]);
        end
      end
    endcase
    if (!take) begin
      cmd.act = ACT_NONE;
    end
  end

  // Build the row of cells; each end sees zero beyond the row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_v;
    logic [ENTRY_WIDTH-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    ile_cell #(
      .IDX         (i),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .wr_data (wr_data),
      .left    (left_v),
      .right   (right_v),
      .entry   (cell_q[i])
    );
  end

  // Hold capacity limit, count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
      count          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_limit <= cfg_wr_data;
      end
      if (take) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (take) begin
      out_status    <= status_next;
      out_read_data <= rd_next;
      out_count     <= count_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.read_data   = out_read_data;
  assign out_ch.entry_count = out_count;

endmodule

### test/indexed_list_engine_unit_tb.sv
// ---------------------------------------------------------------------------
// indexed_list_engine_unit_tb: self-checking bench for the indexed list engine
// Drives insert, append, delete and get beats through the request channel,
// predicts unpinned result beats with an independent list model and checks the
// result channel beat by beat. A short scripted opening covers empty, full,
// range and capacity corner cases; random traffic then grows and drains the
// list under several capacity limits and several idle and stall mixes.
// ---------------------------------------------------------------------------
module indexed_list_engine_unit_tb;
  import ile_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 160;
  localparam int SCRIPT_LEN  = 29;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [CNT_W-1:0]    entry_count;
  } reply_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [MODE_W-1:0] op;
    logic [POS_W-1:0]  at;
    logic [DATA_W-1:0] value;   // capacity for a config row
    logic              pinned;  // use the typed reply instead of the model
    reply_t            want;
  } script_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  ile_in_if  in_ch ();
  ile_out_if out_ch ();

  indexed_list_engine_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // List model state
  logic [DATA_W-1:0] list_store [LIST_DEPTH];
  logic [CNT_W-1:0]  list_count;
  logic [CNT_W-1:0]  cap_reg;
  reply_t            replies_due [$];

  // Sideband that travels with each request beat
  logic   beat_pinned;
  reply_t beat_want;

  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  int fail_count;
  int beats_in;
  int replies_out;
  int deepest;
  int status_hits [4];

  // Opening script: empty list, middle and tail inserts, range errors,
  // full with bad index, capacity at and below the count, capacity zero
  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_BEAT, MODE_GET,    5'd0,  32'h0,        1'b1, '{ST_RANGE, 32'h0,        5'd0}},
    '{ROW_BEAT, MODE_DELETE, 5'd0,  32'h0,        1'b1, '{ST_RANGE, 32'h0,        5'd0}},
    '{ROW_BEAT, MODE_INSERT, 5'd1,  32'h11111111, 1'b1, '{ST_RANGE, 32'h0,        5'd0}},
    '{ROW_BEAT, MODE_INSERT, 5'd0,  32'hFFFFFFFF, 1'b1, '{ST_DONE,  32'h0,        5'd1}},
    '{ROW_BEAT, MODE_APPEND, 5'd31, 32'h0,        1'b1, '{ST_DONE,  32'h0,        5'd2}},
    '{ROW_BEAT, MODE_GET,    5'd0,  32'h0,        1'b1, '{ST_DONE,  32'hFFFFFFFF, 5'd2}},
    '{ROW_BEAT, MODE_GET,    5'd1,  32'h0,        1'b1, '{ST_DONE,  32'h0,        5'd2}},
    '{ROW_BEAT, MODE_INSERT, 5'd2,  32'hA5A5A5A5, 1'b1, '{ST_DONE,  32'h0,        5'd3}},
    '{ROW_BEAT, MODE_INSERT, 5'd1,  32'h5A5A5A5A, 1'b0, '{ST_DONE,  32'h0,        5'd0}},
    '{ROW_BEAT, MODE_GET,    5'd1,  32'h0,        1'b1, '{ST_DONE,  32'h5A5A5A5A, 5'd4}},
    '{ROW_BEAT, MODE_GET,    5'd3,  32'h0,        1'b1, '{ST_DONE,  32'hA5A5A5A5, 5'd4}},
    '{ROW_BEAT, MODE_GET,    5'd4,  32'h0,        1'b1, '{ST_RANGE, 32'h0,        5'd4}},
    '{ROW_BEAT, MODE_GET,    5'd31, 32'h0,        1'b1, '{ST_RANGE, 32'h0,        5'd4}},
    '{ROW_BEAT, MODE_DELETE, 5'd4,  32'h0,        1'b1, '{ST_RANGE, 32'h0,        5'd4}},
    '{ROW_BEAT, MODE_DELETE, 5'd0,  32'h0,        1'b1, '{ST_DONE,  32'h0,        5'd3}},
    '{ROW_BEAT, MODE_GET,    5'd0,  32'h0,        1'b1, '{ST_DONE,  32'h5A5A5A5A, 5'd3}},
    '{ROW_BEAT, MODE_INSERT, 5'd31, 32'h12345678, 1'b1, '{ST_RANGE, 32'h0,        5'd3}},
    '{ROW_BEAT, MODE_DELETE, 5'd2,  32'h0,        1'b1, '{ST_DONE,  32'h0,        5'd2}},
    '{ROW_CFG,  MODE_GET,    5'd0,  32'd2,        1'b0, '{ST_DONE,  32'h0,        5'd0}},
    '{ROW_BEAT, MODE_INSERT, 5'd31, 32'h0F0F0F0F, 1'b1, '{ST_FULL,  32'h0,        5'd2}},
    '{ROW_BEAT, MODE_APPEND, 5'd0,  32'hDEADBEEF, 1'b1, '{ST_FULL,  32'h0,        5'd2}},
    '{ROW_CFG,  MODE_GET,    5'd0,  32'd1,        1'b0, '{ST_DONE,  32'h0,        5'd0}},
    '{ROW_BEAT, MODE_INSERT, 5'd0,  32'h0F0F0F0F, 1'b1, '{ST_FULL,  32'h0,        5'd2}},
    '{ROW_BEAT, MODE_GET,    5'd1,  32'h0,        1'b1, '{ST_DONE,  32'h0,        5'd2}},
    '{ROW_BEAT, MODE_DELETE, 5'd0,  32'h0,        1'b0, '{ST_DONE,  32'h0,        5'd0}},
    '{ROW_CFG,  MODE_GET,    5'd0,  32'd0,        1'b0, '{ST_DONE,  32'h0,        5'd0}},
    '{ROW_BEAT, MODE_APPEND, 5'd5,  32'hCAFEF00D, 1'b1, '{ST_FULL,  32'h0,        5'd1}},
    '{ROW_BEAT, MODE_INSERT, 5'd0,  32'hCAFEF00D, 1'b1, '{ST_FULL,  32'h0,        5'd1}},
    '{ROW_BEAT, MODE_GET,    5'd0,  32'h0,        1'b1, '{ST_DONE,  32'h0,        5'd1}}
  };

  int idle_mix  [4]      = '{0, 62, 0, 18};
  int stall_mix [4]      = '{0, 0, 62, 18};
  int phase_cap [PHASES] = '{31, 16, 9, 1, 16, 0, 3, 31};

  always #1 clk = ~clk;

  // Apply one operation to the list model and return the reply it yields
  function automatic reply_t apply_list_op(input logic [MODE_W-1:0] op,
                                           input logic [POS_W-1:0]  at,
                                           input logic [DATA_W-1:0] value);
    reply_t r;
    int     room;
    int     slot;
    int     i;
    r    = '0;
    room = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg;
    case (op)
      MODE_INSERT, MODE_APPEND: begin
        // full check wins over a bad index
        if (list_count >= room) begin
          r.status = ST_FULL;
        end else if (op == MODE_INSERT && at > list_count) begin
          r.status = ST_RANGE;
        end else begin
          slot = (op == MODE_APPEND) ? int'(list_count) : int'(at);
          for (i = list_count; i > slot; i--) list_store[i] = list_store[i-1];
          list_store[slot] = value;
          list_count++;
        end
      end
      MODE_DELETE: begin
        if (at >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = at; i + 1 < list_count; i++) list_store[i] = list_store[i+1];
          list_count--;
        end
      end
      MODE_GET: begin
        if (at >= list_count) r.status = ST_RANGE;
        else r.read_data = list_store[at];
      end
    endcase
    r.entry_count = list_count;
    return r;
  endfunction

  // Model update on accepted beats, result check on delivered beats
  always @(posedge clk) begin : list_monitor
    reply_t got;
    reply_t want;
    reply_t predicted;
    cycles++;
    if (rst) begin
      list_count = '0;
      cap_reg    = CAP_RESET;
      replies_due.delete();
    end else begin
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      // check results before taking new requests: a result never answers
      // a request accepted at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.read_data, out_ch.entry_count};
        replies_out++;
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result beat with nothing pending: status %0d data %h count %0d",
                     got.status, got.read_data, got.entry_count);
        end else begin
          want = replies_due.pop_front();
          status_hits[want.status]++;
          if (got.status !== want.status || got.read_data !== want.read_data ||
              got.entry_count !== want.entry_count) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("result %0d: want status %0d data %h count %0d, got %0d %h %0d",
                       replies_out, want.status, want.read_data, want.entry_count,
                       got.status, got.read_data, got.entry_count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted = apply_list_op(in_ch.mode, in_ch.position, in_ch.entry_data);
        replies_due.push_back(beat_pinned ? beat_want : predicted);
        beats_in++;
        if (list_count > deepest) deepest = list_count;
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold a request beat until it is taken, with random gaps ahead of it
  task automatic send_beat(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] at,
                           input logic [DATA_W-1:0] value, input logic pinned,
                           input reply_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= op;
    in_ch.position   <= at;
    in_ch.entry_data <= value;
    beat_pinned      <= pinned;
    beat_want        <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] limit);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One random beat; grow_pct steers the list toward full or toward empty
  task automatic send_random_op(input int grow_pct);
    logic [MODE_W-1:0] op;
    logic [POS_W-1:0]  at;
    logic [DATA_W-1:0] value;
    int                pick;
    pick = $urandom_range(99);
    if (pick < grow_pct) op = $urandom_range(1) ? MODE_INSERT : MODE_APPEND;
    else if (pick < grow_pct + 20) op = MODE_GET;
    else op = MODE_DELETE;
    // mostly aim inside the list, now and then anywhere in the field
    if ($urandom_range(9) < 8) at = POS_W'($urandom_range(list_count));
    else at = POS_W'($urandom_range(31));
    case ($urandom_range(7))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom;
    endcase
    send_beat(op, at, value, 1'b0, '0);
  endtask

  initial begin : stimulus
    int row;
    int ph;
    int k;
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_GET;
    in_ch.position   = '0;
    in_ch.entry_data = '0;
    beat_pinned      = 1'b0;
    beat_want        = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Scripted opening
    for (row = 0; row < SCRIPT_LEN; row++) begin
      if (script[row].kind == ROW_CFG)
        write_capacity(script[row].value[CNT_W-1:0]);
      else
        send_beat(script[row].op, script[row].at, script[row].value,
                  script[row].pinned, script[row].want);
    end

    // Random traffic: alternate grow and drain stretches under each mix
    for (ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_cap[ph][CNT_W-1:0]);
      send_idle_pct  = idle_mix[ph % 4];
      recv_stall_pct = stall_mix[ph % 4];
      for (k = 0; k < PHASE_BEATS; k++)
        send_random_op(((k / 40) % 2 == 0) ? 65 : 15);
    end

    drain_replies();
    repeat (4) @(posedge clk);
    if (replies_due.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", replies_due.size());
    end
    $display("covered %0d requests and %0d results over %0d capacity limits and 4 idle mixes",
             beats_in, replies_out, PHASES + 3);
    $display("status mix done %0d, full %0d, out of range %0d; deepest list %0d entries",
             status_hits[ST_DONE], status_hits[ST_FULL], status_hits[ST_RANGE], deepest);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/ile_pkg.sv
rtl/ile_in_if.sv
rtl/ile_out_if.sv
rtl/ile_cell.sv
rtl/indexed_list_engine_unit.sv
test/indexed_list_engine_unit_tb.sv
